### hdl/qbc_pkg.sv
// Shared types, widths and latencies of the quintic boundary coefficients unit.
package qbc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W = 32;
    localparam int COEF_W = 64;
    localparam int QUOT_W = 64;
    localparam int DUR_W = DATA_W - 1;
    localparam int P2_W = 2 * DUR_W;
    localparam int P3_W = 3 * DUR_W;
    localparam int P4_W = 4 * DUR_W;
    localparam int P5_W = 5 * DUR_W;
    localparam int DEN3_W = P3_W + 1;
    localparam int DEN4_W = P4_W + 1;
    localparam int DEN5_W = P5_W + 1;
    localparam int PROD_W = 96;
    localparam int NUM_W = 104;
    localparam int FRONT_LAT = 7;
    localparam int DIV_LAT = QUOT_W + 3;
    localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT;

    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] start_pos;
        logic signed [DATA_W-1:0] start_vel;
        logic signed [DATA_W-1:0] start_acc;
        logic signed [DATA_W-1:0] end_pos;
        logic signed [DATA_W-1:0] end_vel;
        logic signed [DATA_W-1:0] end_acc;
        logic signed [DATA_W-1:0] duration;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] start_pos;
        logic signed [DATA_W-1:0] start_vel;
        logic signed [DATA_W-1:0] start_acc;
        logic                     bad;
    } side_t;

endpackage

### hdl/quintic_boundary_coefficients_unit.sv
// Top level of the quintic boundary coefficients unit.
// Takes one boundary-condition item per clock while the pipeline advances and returns the
// six quintic coefficients after 7 front-end stages of products and sums, then 67 divider
// stages (load, one per quotient bit, rounding, saturation). The pipeline advances
// whenever the result register is empty or being taken; a one-entry input skid register
// lets one more item be taken while a result waits. No clearing pass is needed after reset.
module quintic_boundary_coefficients_unit import qbc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_start_pos,
    input  logic signed [DATA_W-1:0] s_start_vel,
    input  logic signed [DATA_W-1:0] s_start_acc,
    input  logic signed [DATA_W-1:0] s_end_pos,
    input  logic signed [DATA_W-1:0] s_end_vel,
    input  logic signed [DATA_W-1:0] s_end_acc,
    input  logic signed [DATA_W-1:0] s_duration,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [COEF_W-1:0] m_coef_a0,
    output logic signed [COEF_W-1:0] m_coef_a1,
    output logic signed [COEF_W-1:0] m_coef_a2,
    output logic signed [COEF_W-1:0] m_coef_a3,
    output logic signed [COEF_W-1:0] m_coef_a4,
    output logic signed [COEF_W-1:0] m_coef_a5,
    output logic                     m_bad_duration
);

    in_t                 port_item;
    in_t                 feed;
    in_t                 skid_reg;
    logic                skid_v_reg;
    logic                adv;
    logic [TOTAL_LAT-1:0] vld_reg;
    side_t               side_dly_reg [DIV_LAT];
    side_t               front_side;
    side_t               out_side;

    logic [NUM_W-1:0]    mag3, mag4, mag5;
    logic                neg3, neg4, neg5;
    logic [DEN3_W-1:0]   den3;
    logic [DEN4_W-1:0]   den4;
    logic [DEN5_W-1:0]   den5;
    logic signed [COEF_W-1:0] quot3, quot4, quot5;

    assign port_item.start_pos = s_start_pos;
    assign port_item.start_vel = s_start_vel;
    assign port_item.start_acc = s_start_acc;
    assign port_item.end_pos = s_end_pos;
    assign port_item.end_vel = s_end_vel;
    assign port_item.end_acc = s_end_acc;
    assign port_item.duration = s_duration;

    assign adv = !vld_reg[TOTAL_LAT-1] || m_ready;
    assign s_ready = !skid_v_reg;
    assign feed = skid_v_reg ? skid_reg : port_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            skid_v_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], skid_v_reg || s_valid};
            skid_v_reg <= 1'b0;
        end else if (s_valid && !skid_v_reg) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!adv && !skid_v_reg) begin
            skid_reg <= port_item;
        end
        if (adv) begin
            side_dly_reg[0] <= front_side;
            for (int k = 1; k < DIV_LAT; k++) begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    qbc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk (aclk),
        .en   (adv),
        .item (feed),
        .mag3 (mag3),
        .mag4 (mag4),
        .mag5 (mag5),
        .neg3 (neg3),
        .neg4 (neg4),
        .neg5 (neg5),
        .den3 (den3),
        .den4 (den4),
        .den5 (den5),
        .side (front_side)
    );

    qbc_div #(.MAG_W(NUM_W), .DEN_W(DEN3_W), .SHIFT(32)) u_div3 (
        .aclk (aclk), .en (adv), .mag (mag3), .den (den3), .neg (neg3), .quot (quot3)
    );

    qbc_div #(.MAG_W(NUM_W), .DEN_W(DEN4_W), .SHIFT(32 + FRAC_BITS)) u_div4 (
        .aclk (aclk), .en (adv), .mag (mag4), .den (den4), .neg (neg4), .quot (quot4)
    );

    qbc_div #(.MAG_W(NUM_W), .DEN_W(DEN5_W), .SHIFT(32 + 2 * FRAC_BITS)) u_div5 (
        .aclk (aclk), .en (adv), .mag (mag5), .den (den5), .neg (neg5), .quot (quot5)
    );

    assign out_side = side_dly_reg[DIV_LAT-1];
    assign m_valid = vld_reg[TOTAL_LAT-1];
    assign m_bad_duration = out_side.bad;
    assign m_coef_a0 = out_side.bad ? '0 : (COEF_W'(out_side.start_pos) <<< (DATA_W - FRAC_BITS));
    assign m_coef_a1 = out_side.bad ? '0 : (COEF_W'(out_side.start_vel) <<< (DATA_W - FRAC_BITS));
    assign m_coef_a2 = out_side.bad ? '0
        : (COEF_W'(out_side.start_acc) <<< (DATA_W - 1 - FRAC_BITS));
    assign m_coef_a3 = out_side.bad ? '0 : quot3;
    assign m_coef_a4 = out_side.bad ? '0 : quot4;
    assign m_coef_a5 = out_side.bad ? '0 : quot5;

endmodule

### hdl/qbc_front.sv
// Seven-stage front end that forms the numerators and denominators of the three divisions.
module qbc_front import qbc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              en,
    input  in_t               item,
    output logic [NUM_W-1:0]  mag3,
    output logic [NUM_W-1:0]  mag4,
    output logic [NUM_W-1:0]  mag5,
    output logic              neg3,
    output logic              neg4,
    output logic              neg5,
    output logic [DEN3_W-1:0] den3,
    output logic [DEN4_W-1:0] den4,
    output logic [DEN5_W-1:0] den5,
    output side_t             side
);

    logic [DUR_W-1:0]         s1_p_reg;
    logic [P2_W-1:0]          s1_p2_reg;
    logic signed [63:0]       s1_v0p_reg;
    logic signed [63:0]       s1_a0p_reg;
    logic signed [DATA_W:0]   s1_dx_reg;
    logic signed [DATA_W:0]   s1_dv_reg;
    logic signed [DATA_W:0]   s1_d2_reg;
    side_t                    s1_side_reg;

    logic signed [63:0]       s2_m1_reg;
    logic [P2_W-1:0]          s2_p3l_reg;
    logic [P2_W-1:0]          s2_p3h_reg;
    logic signed [63:0]       s2_acl_reg;
    logic signed [63:0]       s2_ach_reg;
    logic signed [64:0]       s2_d2l_reg;
    logic signed [64:0]       s2_d2h_reg;
    logic signed [63:0]       s2_v0p_reg;
    logic signed [DATA_W:0]   s2_dx_reg;
    logic [DUR_W-1:0]         s2_p_reg;
    side_t                    s2_side_reg;

    logic [P3_W-1:0]          s3_p3_reg;
    logic signed [PROD_W-1:0] s3_acp2_reg;
    logic signed [PROD_W-1:0] s3_d2p2_reg;
    logic signed [64:0]       s3_m1l_reg;
    logic signed [63:0]       s3_m1h_reg;
    logic signed [63:0]       s3_v0p_reg;
    logic signed [DATA_W:0]   s3_dx_reg;
    logic [DUR_W-1:0]         s3_p_reg;
    side_t                    s3_side_reg;

    logic signed [PROD_W-1:0] s4_n0_reg;
    logic signed [PROD_W-1:0] s4_m1p_reg;
    logic [P2_W-1:0]          s4_pp_reg [3];
    logic signed [PROD_W-1:0] s4_d2p2_reg;
    logic [P3_W-1:0]          s4_p3_reg;
    logic [DUR_W-1:0]         s4_p_reg;
    side_t                    s4_side_reg;

    logic signed [NUM_W-1:0]  s5_num3_reg;
    logic signed [NUM_W-1:0]  s5_num4_reg;
    logic signed [NUM_W-1:0]  s5_num5_reg;
    logic [P4_W-1:0]          s5_p4_reg;
    logic [P3_W-1:0]          s5_p3_reg;
    logic [DUR_W-1:0]         s5_p_reg;
    side_t                    s5_side_reg;

    logic [NUM_W-1:0]         s6_mag_reg [3];
    logic [2:0]               s6_neg_reg;
    logic [P2_W-1:0]          s6_pp_reg [4];
    logic [DEN3_W-1:0]        s6_d3_reg;
    logic [DEN4_W-1:0]        s6_d4_reg;
    side_t                    s6_side_reg;

    logic [NUM_W-1:0]         s7_mag_reg [3];
    logic [2:0]               s7_neg_reg;
    logic [DEN3_W-1:0]        s7_d3_reg;
    logic [DEN4_W-1:0]        s7_d4_reg;
    logic [DEN5_W-1:0]        s7_d5_reg;
    side_t                    s7_side_reg;

    logic [P4_W-1:0]          p4_next;
    logic [P5_W-1:0]          p5_next;

    always_comb begin
        p4_next = '0;
        for (int k = 0; k < 3; k++) begin
            p4_next = p4_next + (P4_W'(s4_pp_reg[k]) << (k * DUR_W));
        end
        p5_next = '0;
        for (int k = 0; k < 4; k++) begin
            p5_next = p5_next + (P5_W'(s6_pp_reg[k]) << (k * DUR_W));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_p_reg <= item.duration[DUR_W-1:0];
            s1_p2_reg <= P2_W'(item.duration[DUR_W-1:0]) * P2_W'(item.duration[DUR_W-1:0]);
            s1_v0p_reg <= item.start_vel * $signed({1'b0, item.duration[DUR_W-1:0]});
            s1_a0p_reg <= item.start_acc * $signed({1'b0, item.duration[DUR_W-1:0]});
            s1_dx_reg <= (DATA_W+1)'(item.end_pos) - (DATA_W+1)'(item.start_pos);
            s1_dv_reg <= (DATA_W+1)'(item.end_vel) - (DATA_W+1)'(item.start_vel);
            s1_d2_reg <= (DATA_W+1)'(item.end_acc) - (DATA_W+1)'(item.start_acc);
            s1_side_reg.start_pos <= item.start_pos;
            s1_side_reg.start_vel <= item.start_vel;
            s1_side_reg.start_acc <= item.start_acc;
            s1_side_reg.bad <= (item.duration <= $signed(DATA_W'(0)));

            s2_m1_reg <= (64'(s1_dv_reg) <<< FRAC_BITS) - s1_a0p_reg;
            s2_p3l_reg <= P2_W'(s1_p2_reg[DUR_W-1:0]) * P2_W'(s1_p_reg);
            s2_p3h_reg <= P2_W'(s1_p2_reg[P2_W-1:DUR_W]) * P2_W'(s1_p_reg);
            s2_acl_reg <= s1_side_reg.start_acc * $signed({1'b0, s1_p2_reg[DUR_W-1:0]});
            s2_ach_reg <= s1_side_reg.start_acc * $signed({1'b0, s1_p2_reg[P2_W-1:DUR_W]});
            s2_d2l_reg <= s1_d2_reg * $signed({1'b0, s1_p2_reg[DUR_W-1:0]});
            s2_d2h_reg <= s1_d2_reg * $signed({1'b0, s1_p2_reg[P2_W-1:DUR_W]});
            s2_v0p_reg <= s1_v0p_reg;
            s2_dx_reg <= s1_dx_reg;
            s2_p_reg <= s1_p_reg;
            s2_side_reg <= s1_side_reg;

            s3_p3_reg <= P3_W'(s2_p3l_reg) + (P3_W'(s2_p3h_reg) << DUR_W);
            s3_acp2_reg <= PROD_W'(s2_acl_reg) + (PROD_W'(s2_ach_reg) <<< DUR_W);
            s3_d2p2_reg <= PROD_W'(s2_d2l_reg) + (PROD_W'(s2_d2h_reg) <<< DUR_W);
            s3_m1l_reg <= $signed({1'b0, s2_m1_reg[31:0]}) * $signed({1'b0, s2_p_reg});
            s3_m1h_reg <= $signed(s2_m1_reg[63:32]) * $signed({1'b0, s2_p_reg});
            s3_v0p_reg <= s2_v0p_reg;
            s3_dx_reg <= s2_dx_reg;
            s3_p_reg <= s2_p_reg;
            s3_side_reg <= s2_side_reg;

            s4_n0_reg <= (PROD_W'(s3_dx_reg) <<< (2 * FRAC_BITS + 1)) - s3_acp2_reg
                - (PROD_W'(s3_v0p_reg) <<< (FRAC_BITS + 1));
            s4_m1p_reg <= PROD_W'(s3_m1l_reg) + (PROD_W'(s3_m1h_reg) <<< 32);
            for (int k = 0; k < 3; k++) begin
                s4_pp_reg[k] <= P2_W'(s3_p3_reg[k*DUR_W +: DUR_W]) * P2_W'(s3_p_reg);
            end
            s4_d2p2_reg <= s3_d2p2_reg;
            s4_p3_reg <= s3_p3_reg;
            s4_p_reg <= s3_p_reg;
            s4_side_reg <= s3_side_reg;

            s5_num3_reg <= NUM_W'(s4_n0_reg) * 10 - NUM_W'(s4_m1p_reg) * 8
                + NUM_W'(s4_d2p2_reg);
            s5_num4_reg <= NUM_W'(s4_m1p_reg) * 14 - NUM_W'(s4_n0_reg) * 15
                - NUM_W'(s4_d2p2_reg) * 2;
            s5_num5_reg <= NUM_W'(s4_n0_reg) * 6 - NUM_W'(s4_m1p_reg) * 6
                + NUM_W'(s4_d2p2_reg);
            s5_p4_reg <= p4_next;
            s5_p3_reg <= s4_p3_reg;
            s5_p_reg <= s4_p_reg;
            s5_side_reg <= s4_side_reg;

            s6_neg_reg <= {s5_num5_reg[NUM_W-1], s5_num4_reg[NUM_W-1], s5_num3_reg[NUM_W-1]};
            s6_mag_reg[0] <= s5_num3_reg[NUM_W-1] ? NUM_W'(-s5_num3_reg) : NUM_W'(s5_num3_reg);
            s6_mag_reg[1] <= s5_num4_reg[NUM_W-1] ? NUM_W'(-s5_num4_reg) : NUM_W'(s5_num4_reg);
            s6_mag_reg[2] <= s5_num5_reg[NUM_W-1] ? NUM_W'(-s5_num5_reg) : NUM_W'(s5_num5_reg);
            for (int k = 0; k < 4; k++) begin
                s6_pp_reg[k] <= P2_W'(s5_p4_reg[k*DUR_W +: DUR_W]) * P2_W'(s5_p_reg);
            end
            s6_d3_reg <= {s5_p3_reg, 1'b0};
            s6_d4_reg <= {s5_p4_reg, 1'b0};
            s6_side_reg <= s5_side_reg;

            s7_mag_reg <= s6_mag_reg;
            s7_neg_reg <= s6_neg_reg;
            s7_d3_reg <= s6_d3_reg;
            s7_d4_reg <= s6_d4_reg;
            s7_d5_reg <= {p5_next, 1'b0};
            s7_side_reg <= s6_side_reg;
        end
    end

    assign mag3 = s7_mag_reg[0];
    assign mag4 = s7_mag_reg[1];
    assign mag5 = s7_mag_reg[2];
    assign neg3 = s7_neg_reg[0];
    assign neg4 = s7_neg_reg[1];
    assign neg5 = s7_neg_reg[2];
    assign den3 = s7_d3_reg;
    assign den4 = s7_d4_reg;
    assign den5 = s7_d5_reg;
    assign side = s7_side_reg;

endmodule

### hdl/qbc_div.sv
// Pipelined restoring divider giving a rounded, saturated signed Q32.32 quotient.
module qbc_div import qbc_pkg::*; #(
    parameter int MAG_W = NUM_W,
    parameter int DEN_W = DEN3_W,
    parameter int SHIFT = 32
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [MAG_W-1:0]         mag,
    input  logic [DEN_W-1:0]         den,
    input  logic                     neg,
    output logic signed [COEF_W-1:0] quot
);

    localparam int MW = MAG_W + SHIFT;
    localparam int TOP_W = MW - QUOT_W;
    localparam int CW = (TOP_W > DEN_W) ? TOP_W : DEN_W;

    logic [MW-1:0]     dividend;
    logic [TOP_W-1:0]  top_part;
    logic              ovf_next;

    logic [DEN_W-1:0]  r_reg   [QUOT_W+1];
    logic [QUOT_W-1:0] lo_reg  [QUOT_W];
    logic [QUOT_W-1:0] q_reg   [QUOT_W+1];
    logic [DEN_W-1:0]  d_reg   [QUOT_W+1];
    logic              neg_reg [QUOT_W+1];
    logic              ovf_reg [QUOT_W+1];

    logic [DEN_W:0]    shl   [1:QUOT_W];
    logic [DEN_W+1:0]  dif   [1:QUOT_W];
    logic [DEN_W-1:0]  r_next [1:QUOT_W];
    logic              bit_next [1:QUOT_W];

    logic              round_next;
    logic [QUOT_W:0]   qr_reg;
    logic              neg_f_reg;
    logic              ovf_f_reg;
    logic [COEF_W-1:0] quot_next;
    logic [COEF_W-1:0] quot_reg;

    assign dividend = {mag, {SHIFT{1'b0}}};
    assign top_part = dividend[MW-1:QUOT_W];
    assign ovf_next = CW'(top_part) >= CW'(den);

    always_comb begin
        for (int k = 1; k <= QUOT_W; k++) begin
            shl[k] = {r_reg[k-1], lo_reg[k-1][QUOT_W-1]};
            dif[k] = {1'b0, shl[k]} - {2'b00, d_reg[k-1]};
            bit_next[k] = !dif[k][DEN_W+1];
            r_next[k] = dif[k][DEN_W+1] ? shl[k][DEN_W-1:0] : dif[k][DEN_W-1:0];
        end
    end

    assign round_next = {r_reg[QUOT_W], 1'b0} >= {1'b0, d_reg[QUOT_W]};

    always_comb begin
        if (ovf_f_reg || qr_reg[QUOT_W]) begin
            quot_next = neg_f_reg ? COEF_MIN : COEF_MAX;
        end else if (!neg_f_reg) begin
            quot_next = qr_reg[QUOT_W-1] ? COEF_MAX : qr_reg[QUOT_W-1:0];
        end else if (qr_reg[QUOT_W-1:0] > COEF_MIN) begin
            quot_next = COEF_MIN;
        end else begin
            quot_next = -qr_reg[QUOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0] <= DEN_W'(top_part);
            lo_reg[0] <= dividend[QUOT_W-1:0];
            q_reg[0] <= '0;
            d_reg[0] <= den;
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf_next;
            for (int k = 1; k <= QUOT_W; k++) begin
                r_reg[k] <= r_next[k];
                q_reg[k] <= {q_reg[k-1][QUOT_W-2:0], bit_next[k]};
                d_reg[k] <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
            for (int k = 1; k < QUOT_W; k++) begin
                lo_reg[k] <= {lo_reg[k-1][QUOT_W-2:0], 1'b0};
            end
            qr_reg <= {1'b0, q_reg[QUOT_W]} + (QUOT_W+1)'(round_next);
            neg_f_reg <= neg_reg[QUOT_W];
            ovf_f_reg <= ovf_reg[QUOT_W];
            quot_reg <= quot_next;
        end
    end

    assign quot = $signed(quot_reg);

endmodule

### hdl/qbc_chk.sv
// Port-level checker for the quintic boundary coefficients unit and its bind.
module qbc_chk import qbc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [COEF_W-1:0] m_coef_a0,
    input logic signed [COEF_W-1:0] m_coef_a1,
    input logic signed [COEF_W-1:0] m_coef_a2,
    input logic signed [COEF_W-1:0] m_coef_a3,
    input logic signed [COEF_W-1:0] m_coef_a4,
    input logic signed [COEF_W-1:0] m_coef_a5,
    input logic                     m_bad_duration
);

    // A held result must stay valid and keep coefficients a3 and a5 unchanged while it waits.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coef_a5) && $stable(m_coef_a3))
        else $error("result changed while stalled");

    // A bad duration gives all-zero coefficients.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_duration |-> m_coef_a0 == '0 && m_coef_a1 == '0
            && m_coef_a2 == '0 && m_coef_a3 == '0 && m_coef_a4 == '0 && m_coef_a5 == '0)
        else $error("nonzero coefficient with bad duration");

    // The constant coefficient is the start position scaled up, so its low bits are zero.
    a_a0_align: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_coef_a0[DATA_W-FRAC_BITS-1:0] == '0)
        else $error("constant coefficient misaligned");

    // The skid register only fills while a result is waiting.
    a_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input blocked with no result pending");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

endmodule

bind quintic_boundary_coefficients_unit qbc_chk #(.FRAC_BITS(FRAC_BITS)) u_qbc_chk (.*);

### tb/testbench.sv
// Self-checking testbench for the quintic boundary coefficients unit.
module testbench import qbc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int RANDOM_ITEMS = 1620;
    localparam int QUIET_LIMIT = 4000;

    typedef logic [255:0] wide_t;

    typedef struct {
        logic [COEF_W-1:0] a0, a1, a2, a3, a4, a5;
        logic              bad;
    } coefs_t;

    function automatic wide_t widen(longint v);
        return {{192{v[63]}}, v};
    endfunction

    // Rounds num / den to nearest, halves away from zero, and saturates to 64 bits.
    function automatic logic [COEF_W-1:0] rounded_quotient(wide_t num, wide_t den);
        logic  neg;
        wide_t mag, q, r;
        neg = num[255];
        mag = neg ? wide_t'(0) - num : num;
        q = mag / den;
        r = mag % den;
        if ((r << 1) >= den)
            q = q + 1;
        if (q[255:64] != 0)
            return neg ? COEF_MIN : COEF_MAX;
        if (!neg)
            return (q[63:0] > COEF_MAX) ? COEF_MAX : q[63:0];
        if (q[63:0] > COEF_MIN)
            return COEF_MIN;
        return 64'd0 - q[63:0];
    endfunction

    function automatic coefs_t solve_quintic(in_t it);
        coefs_t c;
        longint x0, v0, ac0, x1, v1, ac1, t;
        wide_t  p, p2, p3, n0, m1, d2, num;
        x0 = it.start_pos;
        v0 = it.start_vel;
        ac0 = it.start_acc;
        x1 = it.end_pos;
        v1 = it.end_vel;
        ac1 = it.end_acc;
        t = it.duration;
        c = '{default: '0};
        if (t <= 0) begin
            c.bad = 1'b1;
            return c;
        end
        p = widen(t);
        p2 = p * p;
        p3 = p2 * p;
        n0 = widen(x1 - x0) << (2 * FRAC + 1);
        n0 = n0 - widen(ac0) * p2;
        n0 = n0 - ((widen(v0) * p) << (FRAC + 1));
        m1 = (widen(v1 - v0) << FRAC) - widen(ac0) * p;
        d2 = widen(ac1 - ac0);
        c.a0 = 64'(x0) << (32 - FRAC);
        c.a1 = 64'(v0) << (32 - FRAC);
        c.a2 = 64'(ac0) << (31 - FRAC);
        num = wide_t'(10) * n0 - wide_t'(8) * (m1 * p) + d2 * p2;
        c.a3 = rounded_quotient(num << 32, p3 << 1);
        num = wide_t'(0) - wide_t'(15) * n0 + wide_t'(14) * (m1 * p) - wide_t'(2) * (d2 * p2);
        c.a4 = rounded_quotient(num << (32 + FRAC), (p3 * p) << 1);
        num = wide_t'(6) * n0 - wide_t'(6) * (m1 * p) + d2 * p2;
        c.a5 = rounded_quotient(num << (32 + 2 * FRAC), (p3 * p2) << 1);
        return c;
    endfunction

    class coef_scoreboard;
        coefs_t pending[$];
        int     errors = 0;

        function void note_input(in_t it);
            pending.push_back(solve_quintic(it));
        endfunction

        function void check_result(coefs_t got);
            coefs_t want;
            if (pending.size() == 0) begin
                $error("Result transfer with no expected result waiting");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.a0 !== want.a0) begin
                $error("coef_a0: expected %h, actual %h", want.a0, got.a0);
                errors++;
            end
            if (got.a1 !== want.a1) begin
                $error("coef_a1: expected %h, actual %h", want.a1, got.a1);
                errors++;
            end
            if (got.a2 !== want.a2) begin
                $error("coef_a2: expected %h, actual %h", want.a2, got.a2);
                errors++;
            end
            if (got.a3 !== want.a3) begin
                $error("coef_a3: expected %h, actual %h", want.a3, got.a3);
                errors++;
            end
            if (got.a4 !== want.a4) begin
                $error("coef_a4: expected %h, actual %h", want.a4, got.a4);
                errors++;
            end
            if (got.a5 !== want.a5) begin
                $error("coef_a5: expected %h, actual %h", want.a5, got.a5);
                errors++;
            end
            if (got.bad !== want.bad) begin
                $error("bad_duration: expected %b, actual %b", want.bad, got.bad);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [DATA_W-1:0] s_start_pos = '0, s_start_vel = '0, s_start_acc = '0;
    logic signed [DATA_W-1:0] s_end_pos = '0, s_end_vel = '0, s_end_acc = '0;
    logic signed [DATA_W-1:0] s_duration = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [COEF_W-1:0] m_coef_a0, m_coef_a1, m_coef_a2;
    logic signed [COEF_W-1:0] m_coef_a3, m_coef_a4, m_coef_a5;
    logic m_bad_duration;

    coef_scoreboard sb = new();
    bit calm_sender = 0;
    bit calm_receiver = 0;
    int quiet_cycles = 0;

    quintic_boundary_coefficients_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_pos(s_start_pos), .s_start_vel(s_start_vel), .s_start_acc(s_start_acc),
        .s_end_pos(s_end_pos), .s_end_vel(s_end_vel), .s_end_acc(s_end_acc),
        .s_duration(s_duration),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_coef_a0(m_coef_a0), .m_coef_a1(m_coef_a1), .m_coef_a2(m_coef_a2),
        .m_coef_a3(m_coef_a3), .m_coef_a4(m_coef_a4), .m_coef_a5(m_coef_a5),
        .m_bad_duration(m_bad_duration)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        coefs_t got;
        if (aresetn && m_valid && m_ready) begin
            got.a0 = m_coef_a0;
            got.a1 = m_coef_a1;
            got.a2 = m_coef_a2;
            got.a3 = m_coef_a3;
            got.a4 = m_coef_a4;
            got.a5 = m_coef_a5;
            got.bad = m_bad_duration;
            sb.check_result(got);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = calm_receiver ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_item(in_t it);
        int gap;
        gap = calm_sender ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_start_pos <= it.start_pos;
        s_start_vel <= it.start_vel;
        s_start_acc <= it.start_acc;
        s_end_pos <= it.end_pos;
        s_end_vel <= it.end_vel;
        s_end_acc <= it.end_acc;
        s_duration <= it.duration;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_duration();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 32'd0 : 32'h8000_0000 | $urandom;
            1: return $urandom_range(1, 64);
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            3, 4: return $urandom_range(1 << 14, 1 << 19);
            default: return $urandom & 32'h7fff_ffff;
        endcase
    endfunction

    task automatic send_directed();
        in_t it;
        logic [DATA_W-1:0] durs [8] = '{32'd0, 32'hffff_ffff, 32'h8000_0000, 32'd1,
                                        32'd65536, 32'h7fff_ffff, 32'd3, 32'd32768};
        foreach (durs[k]) begin
            it = '{default: '0};
            it.end_pos = 32'd65536;
            it.duration = durs[k];
            send_item(it);
        end
        for (int k = 0; k < 6; k++) begin
            it = '{default: '0};
            it.duration = (k < 3) ? 32'd1 : 32'h7fff_ffff;
            it.start_pos = (k % 3 == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            it.start_vel = (k % 3 == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            it.start_acc = (k % 3 == 2) ? 32'h8000_0000 : 32'h7fff_ffff;
            it.end_pos = ~it.start_pos;
            it.end_vel = ~it.start_vel;
            it.end_acc = ~it.start_acc;
            send_item(it);
        end
        it = '{default: 32'hffff_ffff};
        it.duration = 32'd65536;
        send_item(it);
    endtask

    initial begin
        in_t it;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_directed();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                calm_sender = ($urandom_range(0, 3) == 0);
                calm_receiver = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_ITEMS / 2) begin
                s_valid <= 1'b0;
                wait (sb.pending.size() == 0);
                @(posedge aclk);
            end
            it.start_pos = pick_value();
            it.start_vel = pick_value();
            it.start_acc = pick_value();
            it.end_pos = pick_value();
            it.end_vel = pick_value();
            it.end_acc = pick_value();
            it.duration = pick_duration();
            send_item(it);
        end
        s_valid <= 1'b0;
        wait (sb.pending.size() == 0);
        repeat (TOTAL_LAT + 20) @(posedge aclk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
hdl/qbc_pkg.sv
hdl/qbc_front.sv
hdl/qbc_div.sv
hdl/quintic_boundary_coefficients_unit.sv
hdl/qbc_chk.sv
tb/testbench.sv
